// ----- rtl/core/akt_pkg.sv -----
// Shared types and constants for the analog key trigger block.
`default_nettype none

package akt_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int LEVEL_W    = 15;
    localparam int DELTA_W    = 16;

    typedef enum logic [1:0] {
        MODE_DIGITAL = 2'd0,
        MODE_NORMAL  = 2'd1,
        MODE_RAPID   = 2'd2,
        MODE_SPEED   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE            = 3'd0,
        REG_ACTIVATION      = 3'd1,
        REG_HYSTERESIS      = 3'd2,
        REG_TOP_DEADZONE    = 3'd3,
        REG_BOTTOM_DEADZONE = 3'd4,
        REG_PRESS_DELTA     = 3'd5,
        REG_RELEASE_DELTA   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        t_mode                     mode;
        logic [LEVEL_W-1:0]        activation_level;
        logic [LEVEL_W-1:0]        hysteresis;
        logic [LEVEL_W-1:0]        top_deadzone;
        logic [LEVEL_W-1:0]        bottom_deadzone;
        logic signed [DELTA_W-1:0] press_delta;
        logic signed [DELTA_W-1:0] release_delta;
    } t_cfg;

    localparam logic [LEVEL_W-1:0]        RST_ACTIVATION    = 15'd8192;
    localparam logic [LEVEL_W-1:0]        RST_HYSTERESIS    = 15'd0;
    localparam logic [LEVEL_W-1:0]        RST_TOP_DEADZONE  = 15'd0;
    localparam logic [LEVEL_W-1:0]        RST_BOT_DEADZONE  = 15'd0;
    localparam logic signed [DELTA_W-1:0] RST_PRESS_DELTA   = 16'sd1638;
    localparam logic signed [DELTA_W-1:0] RST_RELEASE_DELTA = 16'sd1638;

endpackage

`default_nettype wire

// ----- rtl/core/akt_channels.sv -----
// Valid/ready channel interfaces for key samples and key results.
`default_nettype none

interface akt_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

interface akt_result_if;
    logic valid;
    logic ready;
    logic pressed;
    logic press_event;
    logic release_event;

    modport source (output valid, output pressed, output press_event,
                    output release_event, input ready);
    modport sink   (input valid, input pressed, input press_event,
                    input release_event, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/akt_cfg_regs.sv -----
// Configuration register file of the analog key trigger block.
`default_nettype none

module akt_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_we,
    input  wire logic [akt_pkg::CFG_IDX_W-1:0]    i_idx,
    input  wire logic [akt_pkg::CFG_DATA_W-1:0]   i_data,
    output akt_pkg::t_cfg                         o_cfg
);

    akt_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode             <= akt_pkg::MODE_DIGITAL;
            r_cfg.activation_level <= akt_pkg::RST_ACTIVATION;
            r_cfg.hysteresis       <= akt_pkg::RST_HYSTERESIS;
            r_cfg.top_deadzone     <= akt_pkg::RST_TOP_DEADZONE;
            r_cfg.bottom_deadzone  <= akt_pkg::RST_BOT_DEADZONE;
            r_cfg.press_delta      <= akt_pkg::RST_PRESS_DELTA;
            r_cfg.release_delta    <= akt_pkg::RST_RELEASE_DELTA;
        end else if (i_we) begin
            case (akt_pkg::t_reg_idx'(i_idx))
                akt_pkg::REG_MODE: begin
                    r_cfg.mode <= akt_pkg::t_mode'(i_data[1:0]);
                end
                akt_pkg::REG_ACTIVATION: begin
                    r_cfg.activation_level <= i_data[akt_pkg::LEVEL_W-1:0];
                end
                akt_pkg::REG_HYSTERESIS: begin
                    r_cfg.hysteresis <= i_data[akt_pkg::LEVEL_W-1:0];
                end
                akt_pkg::REG_TOP_DEADZONE: begin
                    r_cfg.top_deadzone <= i_data[akt_pkg::LEVEL_W-1:0];
                end
                akt_pkg::REG_BOTTOM_DEADZONE: begin
                    r_cfg.bottom_deadzone <= i_data[akt_pkg::LEVEL_W-1:0];
                end
                akt_pkg::REG_PRESS_DELTA: begin
                    r_cfg.press_delta <= $signed(i_data[akt_pkg::DELTA_W-1:0]);
                end
                akt_pkg::REG_RELEASE_DELTA: begin
                    r_cfg.release_delta <= $signed(i_data[akt_pkg::DELTA_W-1:0]);
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/core/akt_decide.sv -----
// Per-sample key decision: digital, Schmitt, rapid trigger and speed modes.
`default_nettype none

module akt_decide #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire akt_pkg::t_cfg                i_cfg,
    input  wire logic signed [SAMPLE_BITS-1:0] i_pos,
    input  wire logic                         i_key_down,
    input  wire logic signed [SAMPLE_BITS-1:0] i_last,
    input  wire logic signed [SAMPLE_BITS-1:0] i_low,
    input  wire logic signed [SAMPLE_BITS-1:0] i_high,
    output logic                              o_key_down,
    output logic signed [SAMPLE_BITS-1:0]     o_last,
    output logic signed [SAMPLE_BITS-1:0]     o_low,
    output logic signed [SAMPLE_BITS-1:0]     o_high
);

    // Compare width: wide enough that no sum or difference below can wrap.
    localparam int CW = ((SAMPLE_BITS > akt_pkg::DELTA_W) ? SAMPLE_BITS
                                                          : akt_pkg::DELTA_W) + 2;
    localparam int ZW = CW - akt_pkg::LEVEL_W;
    localparam logic signed [CW-1:0] FULL = CW'(64'sd1 <<< (SAMPLE_BITS - 2));

    logic signed [CW-1:0] v;
    logic signed [CW-1:0] act;
    logic signed [CW-1:0] hys;
    logic signed [CW-1:0] top_dz;
    logic signed [CW-1:0] bot_dz;
    logic signed [CW-1:0] pd;
    logic signed [CW-1:0] rd;
    logic signed [CW-1:0] low_x;
    logic signed [CW-1:0] high_x;
    logic signed [CW-1:0] speed;
    logic signed [CW-1:0] high_mid;

    always_comb begin
        v      = CW'(i_pos);
        act    = $signed({{ZW{1'b0}}, i_cfg.activation_level});
        hys    = $signed({{ZW{1'b0}}, i_cfg.hysteresis});
        top_dz = $signed({{ZW{1'b0}}, i_cfg.top_deadzone});
        bot_dz = $signed({{ZW{1'b0}}, i_cfg.bottom_deadzone});
        pd     = CW'(i_cfg.press_delta);
        rd     = CW'(i_cfg.release_delta);
        low_x  = CW'(i_low);
        high_x = CW'(i_high);
        speed  = v - CW'(i_last);
        high_mid = high_x;

        o_key_down = i_key_down;
        o_last     = i_last;
        o_low      = i_low;
        o_high     = i_high;

        case (i_cfg.mode)
            akt_pkg::MODE_DIGITAL: begin
                o_key_down = (i_pos != '0);
            end
            akt_pkg::MODE_NORMAL: begin
                o_last = i_pos;
                if (v - hys > act) begin
                    o_key_down = 1'b1;
                end
                if (v + hys < act) begin
                    o_key_down = 1'b0;
                end
            end
            akt_pkg::MODE_RAPID: begin
                o_last = i_pos;
                if (v <= top_dz) begin
                    o_key_down = 1'b0;
                    o_low      = i_pos;
                end else if (v >= FULL - bot_dz) begin
                    o_key_down = 1'b1;
                    o_high     = i_pos;
                end else if (i_key_down) begin
                    // The release test sees the maximum as just updated.
                    if ((v - low_x >= pd) && (v > high_x)) begin
                        high_mid = v;
                        o_high   = i_pos;
                    end
                    if (high_mid - v >= rd) begin
                        o_low      = i_pos;
                        o_key_down = 1'b0;
                    end
                end else begin
                    if (v - low_x >= pd) begin
                        high_mid   = v;
                        o_high     = i_pos;
                        o_key_down = 1'b1;
                    end
                    if ((high_mid - v >= rd) && (v < low_x)) begin
                        o_low = i_pos;
                    end
                end
            end
            akt_pkg::MODE_SPEED: begin
                if (speed > pd) begin
                    o_key_down = 1'b1;
                end
                if (speed < rd) begin
                    o_key_down = 1'b0;
                end
                o_last = i_pos;
            end
            default: begin
                o_key_down = i_key_down;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/analog_key_trigger_top.sv -----
// Top level of the analog key trigger block.
// Takes one signed key-travel sample per word (full travel is 1 << (SAMPLE_BITS-2))
// and returns one result word per sample: the pressed state and press and release
// edge flags. A sample is registered on acceptance, decided by a single compare
// stage against the key state registers, and held in the result register until
// taken. One sample per cycle is sustained while the result side is ready; the rate
// is set by that one decision stage, which reads and updates the key state in the
// same cycle. Configuration is to be written through the register write port only
// while no samples are in flight; the block itself does not enforce this. Unknown
// register indexes are ignored.
`default_nettype none

module analog_key_trigger_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [akt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [akt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    akt_sample_if.sink                            i_sample,
    akt_result_if.source                          o_result
);

    akt_pkg::t_cfg cfg;

    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_pos;
    logic                          r_out_valid;
    logic                          r_pressed;
    logic                          r_press_event;
    logic                          r_release_event;

    logic                          r_key_down;
    logic signed [SAMPLE_BITS-1:0] r_last;
    logic signed [SAMPLE_BITS-1:0] r_low;
    logic signed [SAMPLE_BITS-1:0] r_high;

    logic                          n_key_down;
    logic signed [SAMPLE_BITS-1:0] n_last;
    logic signed [SAMPLE_BITS-1:0] n_low;
    logic signed [SAMPLE_BITS-1:0] n_high;

    logic advance;
    logic in_take;

    akt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    akt_decide #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_decide (
        .i_cfg      (cfg),
        .i_pos      (r_in_pos),
        .i_key_down (r_key_down),
        .i_last     (r_last),
        .i_low      (r_low),
        .i_high     (r_high),
        .o_key_down (n_key_down),
        .o_last     (n_last),
        .o_low      (n_low),
        .o_high     (n_high)
    );

    // The held sample moves on whenever the result register is free or being drained.
    assign advance = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_take = i_sample.valid && i_sample.ready;

    assign i_sample.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_key_down  <= 1'b0;
            r_last      <= '0;
            r_low       <= '0;
            r_high      <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                r_key_down  <= n_key_down;
                r_last      <= n_last;
                r_low       <= n_low;
                r_high      <= n_high;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pos <= i_sample.position;
        end
        if (advance) begin
            r_pressed       <= n_key_down;
            r_press_event   <= !r_key_down && n_key_down;
            r_release_event <= r_key_down && !n_key_down;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.pressed       = r_pressed;
    assign o_result.press_event   = r_press_event;
    assign o_result.release_event = r_release_event;

endmodule

`default_nettype wire

// ----- bench/akt_key_checker.sv -----
// Checker for the analog key trigger: predicts each result word and compares it.
`timescale 1ns / 100ps

module akt_key_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [akt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [akt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_sample_valid,
    input  wire logic                                i_sample_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_position,
    input  wire logic                                i_result_valid,
    input  wire logic                                i_result_ready,
    input  wire logic                                i_pressed,
    input  wire logic                                i_press_event,
    input  wire logic                                i_release_event,
    output int                                       o_failures,
    output int                                       o_pending
);

    localparam longint FULL_TRAVEL = longint'(1) << (SAMPLE_BITS - 2);

    typedef struct {
        logic pressed;
        logic press_event;
        logic release_event;
    } t_key_word;

    t_key_word key_words_due[$];

    // Configuration as the block should hold it.
    akt_pkg::t_mode key_mode;
    longint         activation;
    longint         hysteresis;
    longint         top_zone;
    longint         bottom_zone;
    longint         press_dist;
    longint         release_dist;

    // Key state as the block should hold it.
    logic   key_down;
    longint last_pos;
    longint low_mark;
    longint high_mark;

    initial o_failures = 0;
    initial o_pending  = 0;

    function automatic t_key_word advance_key(input longint pos);
        t_key_word word;
        logic      was_down;
        logic      now_down;
        was_down = key_down;
        now_down = key_down;
        case (key_mode)
            akt_pkg::MODE_DIGITAL: begin
                now_down = (pos != 0);
            end
            akt_pkg::MODE_NORMAL: begin
                last_pos = pos;
                if (pos - hysteresis > activation) now_down = 1'b1;
                if (pos + hysteresis < activation) now_down = 1'b0;
            end
            akt_pkg::MODE_RAPID: begin
                last_pos = pos;
                // The top deadzone is tested first; either deadzone skips the
                // distance checks entirely.
                if (pos <= top_zone) begin
                    now_down = 1'b0;
                    low_mark = pos;
                end else if (pos >= FULL_TRAVEL - bottom_zone) begin
                    now_down  = 1'b1;
                    high_mark = pos;
                end else if (was_down) begin
                    if (pos - low_mark >= press_dist && pos > high_mark) high_mark = pos;
                    if (high_mark - pos >= release_dist) begin
                        low_mark = pos;
                        now_down = 1'b0;
                    end
                end else begin
                    // The second test sees the high mark the first one may have moved.
                    if (pos - low_mark >= press_dist) begin
                        high_mark = pos;
                        now_down  = 1'b1;
                    end
                    if (high_mark - pos >= release_dist && pos < low_mark) low_mark = pos;
                end
            end
            default: begin
                if (pos - last_pos > press_dist)   now_down = 1'b1;
                if (pos - last_pos < release_dist) now_down = 1'b0;
                last_pos = pos;
            end
        endcase
        key_down           = now_down;
        word.pressed       = now_down;
        word.press_event   = !was_down && now_down;
        word.release_event = was_down && !now_down;
        return word;
    endfunction

    function automatic void compare_field(input string name, input logic want,
                                          input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            o_failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_key_word want;
        if (!i_rst_n) begin
            key_mode     = akt_pkg::MODE_DIGITAL;
            activation   = longint'(akt_pkg::RST_ACTIVATION);
            hysteresis   = longint'(akt_pkg::RST_HYSTERESIS);
            top_zone     = longint'(akt_pkg::RST_TOP_DEADZONE);
            bottom_zone  = longint'(akt_pkg::RST_BOT_DEADZONE);
            press_dist   = longint'(akt_pkg::RST_PRESS_DELTA);
            release_dist = longint'(akt_pkg::RST_RELEASE_DELTA);
            key_down     = 1'b0;
            last_pos     = '0;
            low_mark     = '0;
            high_mark    = '0;
            key_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    akt_pkg::REG_MODE:
                        key_mode = akt_pkg::t_mode'(i_cfg_data[1:0]);
                    akt_pkg::REG_ACTIVATION:
                        activation = longint'(i_cfg_data[akt_pkg::LEVEL_W-1:0]);
                    akt_pkg::REG_HYSTERESIS:
                        hysteresis = longint'(i_cfg_data[akt_pkg::LEVEL_W-1:0]);
                    akt_pkg::REG_TOP_DEADZONE:
                        top_zone = longint'(i_cfg_data[akt_pkg::LEVEL_W-1:0]);
                    akt_pkg::REG_BOTTOM_DEADZONE:
                        bottom_zone = longint'(i_cfg_data[akt_pkg::LEVEL_W-1:0]);
                    akt_pkg::REG_PRESS_DELTA:
                        press_dist = longint'($signed(i_cfg_data));
                    akt_pkg::REG_RELEASE_DELTA:
                        release_dist = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_result_valid && i_result_ready) begin
                if (key_words_due.size() == 0) begin
                    $error("result word arrived with no sample waiting for it");
                    o_failures++;
                end else begin
                    want = key_words_due.pop_front();
                    compare_field("pressed", want.pressed, i_pressed);
                    compare_field("press_event", want.press_event, i_press_event);
                    compare_field("release_event", want.release_event, i_release_event);
                end
            end
            if (i_sample_valid && i_sample_ready)
                key_words_due.push_back(advance_key(longint'(i_position)));
        end
        o_pending = key_words_due.size();
    end

endmodule

// ----- bench/analog_key_trigger_top_test.sv -----
// Testbench top for the analog key trigger: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module analog_key_trigger_top_test;

    localparam int SAMPLE_BITS = 16;
    localparam int FULL        = 1 << (SAMPLE_BITS - 2);
    localparam int QUIET_LIMIT = 1000;
    localparam int SETTINGS    = 16;
    localparam int PER_SETTING = 30;
    localparam logic [akt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [akt_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [akt_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             failures;
    int                             pending;
    int                             quiet_cycles = 0;
    int                             burst_left = 0;
    int                             track_pos = 0;
    int                             track_step = 500;
    int                             stall_cycle = 0;
    int                             extreme_sel = 0;
    akt_pkg::t_mode                 mode_order [4] = '{akt_pkg::MODE_DIGITAL,
                                                       akt_pkg::MODE_NORMAL,
                                                       akt_pkg::MODE_RAPID,
                                                       akt_pkg::MODE_SPEED};

    akt_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    akt_result_if                              result_ch ();

    analog_key_trigger_top #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (sample_ch),
        .o_result   (result_ch)
    );

    akt_key_checker #(.SAMPLE_BITS(SAMPLE_BITS)) checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_sample_valid  (sample_ch.valid),
        .i_sample_ready  (sample_ch.ready),
        .i_position      (sample_ch.position),
        .i_result_valid  (result_ch.valid),
        .i_result_ready  (result_ch.ready),
        .i_pressed       (result_ch.pressed),
        .i_press_event   (result_ch.press_event),
        .i_release_event (result_ch.release_event),
        .o_failures      (failures),
        .o_pending       (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver cycles through four stall styles, one of them never stalling.
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            stall_cycle++;
            case ((stall_cycle / 97) % 4)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= ((stall_cycle % 7) < 3);
            endcase
        end
    end

    always @(posedge clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_position(input int pos);
        int gap;
        if (burst_left <= 0) begin
            gap        = int'($urandom_range(0, 8));
            burst_left = int'($urandom_range(1, 40));
            if (gap != 0) begin
                @(negedge clk) sample_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        sample_ch.valid    <= 1'b1;
        sample_ch.position <= SAMPLE_BITS'(pos);
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    // Registers are only touched once every sample has come back as a result word.
    task automatic drain_results();
        @(negedge clk) sample_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [akt_pkg::CFG_IDX_W-1:0] idx,
                             input int value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= akt_pkg::CFG_DATA_W'(value);
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    function automatic int pick_level(input int hi);
        int pick;
        if (extreme_sel == 1) return 32767;
        if (extreme_sel == 2) return 0;
        pick = int'($urandom_range(0, 9));
        if (pick == 0) return 0;
        if (pick == 1) return FULL;
        if (pick == 2) return 32767;
        return int'($urandom_range(0, hi));
    endfunction

    function automatic int pick_delta();
        int pick;
        if (extreme_sel == 1) return 32767;
        if (extreme_sel == 2) return -32768;
        pick = int'($urandom_range(0, 9));
        if (pick == 0) return -32768;
        if (pick == 1) return 32767;
        if (pick == 2) return 0;
        return int'($urandom_range(0, 6000)) - 3000;
    endfunction

    // Mostly a key moving up and down its travel, with some in-range jumps and
    // some fully random words mixed in.
    function automatic int next_position();
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 75) begin
            track_pos += int'($urandom_range(0, 2 * track_step)) - track_step;
            if (track_pos < -1500) track_pos = -1500;
            if (track_pos > FULL + 1500) track_pos = FULL + 1500;
            return track_pos;
        end
        if (pick < 88) return int'($urandom_range(0, FULL));
        return int'($urandom());
    endfunction

    initial begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = akt_pkg::REG_MODE;
        cfg_data           = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.position = '0;
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Digital mode out of reset: any nonzero word presses.
        send_position(0);
        send_position(1);
        send_position(-32768);
        send_position(32767);
        send_position(0);
        send_position(-1);

        // Normal mode on the reset threshold: equal to the level holds the state.
        drain_results();
        write_reg(akt_pkg::REG_MODE, int'(akt_pkg::MODE_NORMAL));
        send_position(8191);
        send_position(8192);
        send_position(8193);

        // Rapid trigger on reset distances, then both deadzones.
        drain_results();
        write_reg(akt_pkg::REG_MODE, int'(akt_pkg::MODE_RAPID));
        send_position(3000);
        send_position(1000);
        send_position(3000);
        send_position(FULL);
        send_position(0);

        // Overlapping deadzones: the top one is tested first.
        drain_results();
        write_reg(akt_pkg::REG_TOP_DEADZONE, 9000);
        write_reg(akt_pkg::REG_BOTTOM_DEADZONE, 9000);
        send_position(8000);
        send_position(9500);
        send_position(8000);

        // Speed mode with a negative release speed.
        drain_results();
        write_reg(akt_pkg::REG_MODE, int'(akt_pkg::MODE_SPEED));
        write_reg(akt_pkg::REG_PRESS_DELTA, 500);
        write_reg(akt_pkg::REG_RELEASE_DELTA, -500);
        send_position(8600);
        send_position(8700);
        send_position(8100);
        send_position(32767);
        send_position(-32768);

        for (int s = 0; s < SETTINGS; s++) begin
            drain_results();
            extreme_sel = (s == 1 || s == 2) ? s : 0;
            write_reg(akt_pkg::REG_MODE, int'(mode_order[s % 4]));
            write_reg(akt_pkg::REG_ACTIVATION, pick_level(FULL));
            write_reg(akt_pkg::REG_HYSTERESIS, pick_level(1500));
            write_reg(akt_pkg::REG_TOP_DEADZONE, pick_level(1500));
            write_reg(akt_pkg::REG_BOTTOM_DEADZONE, pick_level(1500));
            write_reg(akt_pkg::REG_PRESS_DELTA, pick_delta());
            write_reg(akt_pkg::REG_RELEASE_DELTA, pick_delta());
            if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, int'($urandom()));
            track_step = int'($urandom_range(20, 3000));
            // Every fifth setting runs the sender without gaps.
            burst_left = (s % 5 == 4) ? PER_SETTING + 1 : 0;
            repeat (PER_SETTING) send_position(next_position());
        end

        drain_results();
        repeat (10) @(negedge clk);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
